FILE: rtl/swpf_pkg.sv
// Package for the servo write packet framer.
// Holds command, result and packet types, kind and register codes, and constants.
// Used by swpf_builder and servo_write_packet_framer_core.
package swpf_pkg;

  localparam logic [2:0] KIND_POSITION = 3'd0;
  localparam logic [2:0] KIND_SPEED    = 3'd1;
  localparam logic [2:0] KIND_TORQUE   = 3'd2;
  localparam logic [2:0] KIND_WORD     = 3'd3;
  localparam logic [2:0] KIND_BYTE     = 3'd4;
  localparam logic [2:0] KIND_RESET    = 3'd5;

  localparam logic REG_POS_MIN = 1'b0;
  localparam logic REG_POS_MAX = 1'b1;

  localparam int          POS_W         = 10;
  localparam logic [9:0]  POS_MIN_RESET = 10'd161;
  localparam logic [9:0]  POS_MAX_RESET = 10'd871;
  localparam logic [15:0] LIMIT_MAX     = 16'd1023;

  localparam logic [7:0] HDR_BYTE      = 8'hff;
  localparam logic [7:0] INSTR_WRITE   = 8'h03;
  localparam logic [7:0] INSTR_RESET   = 8'h06;
  localparam logic [7:0] LEN_WORD      = 8'h05;
  localparam logic [7:0] LEN_BYTE      = 8'h04;
  localparam logic [7:0] LEN_RESET     = 8'h02;
  localparam logic [7:0] ADDR_POSITION = 8'h1e;
  localparam logic [7:0] ADDR_SPEED    = 8'h20;
  localparam logic [7:0] ADDR_TORQUE   = 8'h22;

  localparam int PKT_BYTES = 9;
  localparam logic [3:0] PKT_LEN_WORD  = 4'd9;
  localparam logic [3:0] PKT_LEN_BYTE  = 4'd8;
  localparam logic [3:0] PKT_LEN_RESET = 4'd6;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  servo_id;
    logic [7:0]  reg_addr;
    logic [15:0] value;
  } cmd_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last_byte;
  } result_t;

  typedef struct packed {
    logic                      valid;
    logic [3:0]                len;
    logic [PKT_BYTES-1:0][7:0] bytes;
  } pkt_t;

endpackage

FILE: rtl/swpf_builder.sv
// Packet builder: turns one command into the bytes of one instruction packet.
// Clamps the data value and picks the address for position, speed and torque
// commands, and computes the checksum. Depends on swpf_pkg.
module swpf_builder import swpf_pkg::*; (
  input  cmd_t             cmd,
  input  logic [POS_W-1:0] position_min,
  input  logic [POS_W-1:0] position_max,
  output pkt_t             pkt
);

  logic [15:0] val;
  logic [15:0] pmin;
  logic [15:0] pmax;
  logic [7:0]  sum;

  assign pmin = {{(16-POS_W){1'b0}}, position_min};
  assign pmax = {{(16-POS_W){1'b0}}, position_max};

  always_comb begin
    pkt = '0;
    pkt.valid = 1'b1;
    pkt.len = PKT_LEN_WORD;
    pkt.bytes[0] = HDR_BYTE;
    pkt.bytes[1] = HDR_BYTE;
    pkt.bytes[2] = cmd.servo_id;
    pkt.bytes[3] = LEN_WORD;
    pkt.bytes[4] = INSTR_WRITE;
    pkt.bytes[5] = cmd.reg_addr;
    val = cmd.value;
    unique case (cmd.kind) inside
      KIND_POSITION: begin
        if (cmd.value < pmin) begin
          val = pmin;
        end else if (cmd.value > pmax) begin
          val = pmax;
        end
        pkt.bytes[5] = ADDR_POSITION;
      end
      KIND_SPEED, KIND_TORQUE: begin
        if (cmd.value == '0 || cmd.value > LIMIT_MAX) begin
          val = LIMIT_MAX;
        end
        pkt.bytes[5] = (cmd.kind == KIND_SPEED) ? ADDR_SPEED : ADDR_TORQUE;
      end
      KIND_WORD: begin
      end
      KIND_BYTE: begin
        pkt.len = PKT_LEN_BYTE;
        pkt.bytes[3] = LEN_BYTE;
      end
      KIND_RESET: begin
        pkt.len = PKT_LEN_RESET;
        pkt.bytes[2] = 8'h00;
        pkt.bytes[3] = LEN_RESET;
        pkt.bytes[4] = INSTR_RESET;
        pkt.bytes[5] = 8'h00;
      end
      default: begin
        pkt.valid = 1'b0;
      end
    endcase
    if (cmd.kind != KIND_RESET) begin
      pkt.bytes[6] = val[7:0];
    end
    if (cmd.kind != KIND_RESET && cmd.kind != KIND_BYTE) begin
      pkt.bytes[7] = val[15:8];
    end
    sum = pkt.bytes[2] + pkt.bytes[3] + pkt.bytes[4] + pkt.bytes[5]
        + pkt.bytes[6] + pkt.bytes[7];
    pkt.bytes[pkt.len - 4'd1] = ~sum;
  end

endmodule

FILE: rtl/servo_write_packet_framer_core.sv
// Servo write packet framer, top level.
// Holds the limit registers, the command register and the byte serializer.
// Depends on swpf_pkg and swpf_builder.
//
// Usage:
//   Command channel: a command is taken at a rising edge with start high and
//   busy low. busy is high while the command register holds an item that the
//   serializer has not yet taken.
//   Result channel: one packet byte per cycle on result, marked by strobe.
//   Each packet is sent twice; last_byte marks the final byte of the second
//   copy. The receiver cannot stall; every strobed byte is taken.
//   Config port: cfg_we, cfg_index (0 position_min, 1 position_max) and
//   cfg_data. The user must write it only while the block is idle; the
//   block itself does not enforce this.
// Throughput: set by the one-byte-per-cycle serializer; packets are 9 bytes
//   for positions, speeds, torques and word writes, 8 for byte writes and 6
//   for resets. The next command waits in the command register so the byte
//   stream runs without gaps. Kinds 6 and 7 are taken and dropped.
// Reset: clears all control state and loads the limits 161 and 871.
module servo_write_packet_framer_core import swpf_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  cmd_t             cmd,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [POS_W-1:0] cfg_data,
  output logic             strobe,
  output result_t          result
);

  logic [POS_W-1:0] position_min;
  logic [POS_W-1:0] position_max;
  logic             in_valid;
  cmd_t             in_cmd;
  pkt_t             pkt_next;
  logic             active;
  logic             copy;
  logic [3:0]       idx;
  logic [3:0]       len;
  logic [PKT_BYTES-1:0][7:0] bytes;
  logic             at_end;
  logic             ser_free;
  logic             load;

  assign busy     = in_valid;
  assign at_end   = (idx == len - 4'd1);
  assign ser_free = !active || (at_end && copy);
  assign load     = in_valid && ser_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      position_min <= POS_MIN_RESET;
      position_max <= POS_MAX_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_POS_MIN: position_min <= cfg_data;
        REG_POS_MAX: position_max <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (start && !in_valid) begin
      in_valid <= 1'b1;
    end else if (load) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !in_valid) begin
      in_cmd <= cmd;
    end
  end

  swpf_builder u_builder (
    .cmd          (in_cmd),
    .position_min (position_min),
    .position_max (position_max),
    .pkt          (pkt_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      copy   <= 1'b0;
      idx    <= '0;
    end else if (load) begin
      active <= pkt_next.valid;
      copy   <= 1'b0;
      idx    <= '0;
    end else if (active) begin
      if (at_end) begin
        idx <= '0;
        if (copy) begin
          active <= 1'b0;
        end else begin
          copy <= 1'b1;
        end
      end else begin
        idx <= idx + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bytes <= pkt_next.bytes;
      len   <= pkt_next.len;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= active;
    end
  end

  always_ff @(posedge clk) begin
    result.tx_byte   <= bytes[idx];
    result.last_byte <= copy && at_end;
  end

endmodule
